// ===== rtl/bblur_pkg.sv =====
package bblur_pkg;

    // Field and datapath widths
    localparam int CFG_W    = 11;
    localparam int CH_W     = 8;
    localparam int PIX_W    = 3 * CH_W;
    localparam int SUM_W    = 12;
    localparam int CNT_W    = 4;
    localparam int NUM_W    = SUM_W + 1;
    localparam int RECIP_K  = 18;
    localparam int RECIP_W  = 18;
    localparam int PROD_W   = NUM_W + RECIP_W;

    // Default frame limits
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    // Register values after reset
    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 11'd1024;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 11'd1024;

    // Configuration register indexes
    typedef enum logic
    {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    // Input item kinds
    typedef enum logic
    {
        ACT_PIXEL = 1'b0,
        ACT_FLUSH = 1'b1
    } action_t;

    typedef struct packed
    {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } rgb_t;

    typedef struct packed
    {
        logic [SUM_W-1:0] red;
        logic [SUM_W-1:0] green;
        logic [SUM_W-1:0] blue;
    } sum_t;

    // One pending result between the sum and the divide stage
    typedef struct packed
    {
        sum_t             sum;
        logic [CNT_W-1:0] count;
        logic             frame_last;
    } slot_t;

    // One finished result
    typedef struct packed
    {
        rgb_t pix;
        logic frame_last;
    } res_t;

    // ceil(2^RECIP_K / (2*n)); exact floor for numerators below 2^NUM_W
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] n);
        logic [RECIP_W-1:0] m;
        case (n)
            4'd1:    m = 18'd131072;
            4'd2:    m = 18'd65536;
            4'd3:    m = 18'd43691;
            4'd4:    m = 18'd32768;
            4'd5:    m = 18'd26215;
            4'd6:    m = 18'd21846;
            4'd7:    m = 18'd18725;
            4'd8:    m = 18'd16384;
            4'd9:    m = 18'd14564;
            default: m = '0;
        endcase
        return m;
    endfunction

    // Rounded mean, half up: (2*s + n) / (2*n)
    function automatic logic [CH_W-1:0] avg(input logic [SUM_W-1:0] s,
                                            input logic [CNT_W-1:0] n);
        logic [NUM_W-1:0]  x;
        logic [PROD_W-1:0] p;
        x = {s, 1'b0} + NUM_W'(n);
        p = PROD_W'(x) * PROD_W'(recip(n));
        return p[RECIP_K +: CH_W];
    endfunction

    // Sum of one window column, top and bottom optional
    function automatic sum_t colsum(input rgb_t t, input rgb_t m, input rgb_t b,
                                    input logic use_t, input logic use_b);
        sum_t s;
        s.red   = SUM_W'(m.red)   + (use_t ? SUM_W'(t.red)   : '0)
                                  + (use_b ? SUM_W'(b.red)   : '0);
        s.green = SUM_W'(m.green) + (use_t ? SUM_W'(t.green) : '0)
                                  + (use_b ? SUM_W'(b.green) : '0);
        s.blue  = SUM_W'(m.blue)  + (use_t ? SUM_W'(t.blue)  : '0)
                                  + (use_b ? SUM_W'(b.blue)  : '0);
        return s;
    endfunction

    function automatic sum_t sum_add(input sum_t x, input sum_t y);
        sum_t s;
        s.red   = x.red   + y.red;
        s.green = x.green + y.green;
        s.blue  = x.blue  + y.blue;
        return s;
    endfunction

    // Divide all three channels of one slot
    function automatic res_t div_slot(input slot_t s);
        res_t r;
        r.pix.red    = avg(s.sum.red,   s.count);
        r.pix.green  = avg(s.sum.green, s.count);
        r.pix.blue   = avg(s.sum.blue,  s.count);
        r.frame_last = s.frame_last;
        return r;
    endfunction

endpackage

// ===== rtl/box_blur_3x3_edge_aware.sv =====
// 3x3 edge-aware box blur over an RGB raster stream.
// A result passes the read, sum and output stage registers after the beat that completes its window.
// Throughput: one input beat per cycle while m_axis_tready is high; a row's last beat can yield two
// output beats and the row-start beat behind it yields none, so only output back-pressure holds the input.
// Reset clears counters, window and pipeline valids and sets the frame to 1024x1024;
// the line stores are not cleared and hold nothing until written.
module box_blur_3x3_edge_aware #(
    parameter int MAX_WIDTH  = bblur_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bblur_pkg::MAX_HEIGHT_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // input stream
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [23:0]                 s_axis_tdata,  // in_red, in_green, in_blue
    input  logic                        s_axis_tuser,  // action
    // output stream
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [23:0]                 m_axis_tdata,  // out_red, out_green, out_blue
    output logic                        m_axis_tlast,  // run_last
    output logic                        m_axis_tuser,  // frame_last
    // configuration writes
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic                        cfg_index,
    input  logic [bblur_pkg::CFG_W-1:0] cfg_data
);

    localparam int CFG_W = bblur_pkg::CFG_W;
    localparam int CNT_W = bblur_pkg::CNT_W;
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int WEW   = $clog2(MAX_WIDTH + 1);
    localparam int WCW   = (WEW > CFG_W) ? WEW : CFG_W;
    localparam int ROW_W = $clog2(MAX_HEIGHT + 1);
    localparam int HCW   = (ROW_W > CFG_W) ? ROW_W : CFG_W;

    // Configuration
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic             cfg_wr;

    // Frame position
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;

    // Effective sizes and current position
    logic [WCW-1:0]   w_cmp;
    logic [WEW-1:0]   w_eff;
    logic [COL_W-1:0] w_m1;
    logic [HCW-1:0]   h_cmp;
    logic [ROW_W-1:0] h_eff;
    logic [COL_W-1:0] c_cur;
    logic             virt;
    logic             last_cur;
    logic             drop;
    logic             accept;
    logic             load;
    bblur_pkg::rgb_t  pix_in;
    bblur_pkg::rgb_t  pix_new;

    // Line stores
    bblur_pkg::rgb_t  older_rd;
    bblur_pkg::rgb_t  newer_rd;

    // Read stage
    logic             s1_valid_reg;
    bblur_pkg::rgb_t  s1_pix_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic             s1_virt_reg;
    logic             s1_last_reg;
    logic             s1_row1_reg;
    logic             s1_row2_reg;
    logic             s1_c1_reg;
    logic             s1_c2_reg;
    logic             s1_byp_reg;
    bblur_pkg::rgb_t  s1_byp_pix_reg;
    logic             s1_adv;
    logic             byp_hit;

    // Window: columns one and two of the 3x3, top to bottom
    bblur_pkg::rgb_t  win_a_reg [3];
    bblur_pkg::rgb_t  win_b_reg [3];

    // Sum stage inputs
    bblur_pkg::rgb_t  col_t;
    bblur_pkg::rgb_t  col_m;
    bblur_pkg::rgb_t  col_b;
    bblur_pkg::sum_t  cs_a;
    bblur_pkg::sum_t  cs_b;
    bblur_pkg::sum_t  cs_n;
    logic [1:0]       nrows;
    logic [1:0]       ncols0;
    logic [1:0]       ncols1;
    bblur_pkg::slot_t res0;
    bblur_pkg::slot_t res1;
    logic             r0v;
    logic             r1v;
    bblur_pkg::slot_t slot0_next;
    logic             s1_any;
    logic             s1_two;

    // Sum stage
    logic             s2_valid_reg;
    logic             s2_two_reg;
    bblur_pkg::slot_t s2_slot0_reg;
    bblur_pkg::slot_t s2_slot1_reg;
    logic             s2_adv;
    logic             s2_free;

    // Output stage
    logic             out_valid_reg;
    logic             out_two_reg;
    logic             out_sel_reg;
    bblur_pkg::res_t  out0_reg;
    bblur_pkg::res_t  out1_reg;
    bblur_pkg::res_t  out_cur;
    logic             out_beat;
    logic             out_done;
    logic             out_free;

    // Configuration register writes
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid & cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= bblur_pkg::FRAME_WIDTH_RST;
            height_reg <= bblur_pkg::FRAME_HEIGHT_RST;
        end
        else if (cfg_wr)
        begin
            unique case (bblur_pkg::cfg_reg_t'(cfg_index))
                bblur_pkg::REG_FRAME_WIDTH:  width_reg  <= cfg_data;
                bblur_pkg::REG_FRAME_HEIGHT: height_reg <= cfg_data;
            endcase
        end
    end

    // Clamp sizes to 1..max
    assign w_cmp = WCW'(width_reg);
    assign h_cmp = HCW'(height_reg);

    always_comb
    begin
        if (w_cmp == '0)
        begin
            w_eff = WEW'(1);
        end
        else if (w_cmp > WCW'(MAX_WIDTH))
        begin
            w_eff = WEW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WEW'(w_cmp);
        end

        if (h_cmp == '0)
        begin
            h_eff = ROW_W'(1);
        end
        else if (h_cmp > HCW'(MAX_HEIGHT))
        begin
            h_eff = ROW_W'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = ROW_W'(h_cmp);
        end
    end

    assign w_m1     = COL_W'(w_eff - WEW'(1));
    assign c_cur    = (col_reg > w_m1) ? w_m1 : col_reg;
    assign virt     = (row_reg >= h_eff);
    assign last_cur = (c_cur == w_m1);

    // Flush beats inside the frame are consumed without effect
    assign drop          = (s_axis_tuser == bblur_pkg::ACT_FLUSH) & !virt;
    assign s_axis_tready = !s1_valid_reg | s2_free;
    assign accept        = s_axis_tvalid & s_axis_tready;
    assign load          = accept & !drop;

    assign pix_in.red   = s_axis_tdata[7:0];
    assign pix_in.green = s_axis_tdata[15:8];
    assign pix_in.blue  = s_axis_tdata[23:16];
    assign pix_new      = virt ? '0 : pix_in;

    // Advance column and row; a register write restarts the frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cfg_wr)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (load)
        begin
            if (last_cur)
            begin
                col_reg <= '0;
                row_reg <= virt ? '0 : (row_reg + ROW_W'(1));
            end
            else
            begin
                col_reg <= c_cur + COL_W'(1);
            end
        end
    end

    // Newer row: read and write on the input beat
    bblur_ram #(
        .WIDTH (bblur_pkg::PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_newer_ram (
        .clk     (clk),
        .wr_en   (load & !virt),
        .wr_addr (c_cur),
        .wr_data (pix_new),
        .rd_en   (load),
        .rd_addr (c_cur),
        .rd_data (newer_rd)
    );

    // Older row: takes the newer row's old entry when the read stage moves on
    bblur_ram #(
        .WIDTH (bblur_pkg::PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_older_ram (
        .clk     (clk),
        .wr_en   (s1_adv & !s1_virt_reg),
        .wr_addr (s1_col_reg),
        .wr_data (newer_rd),
        .rd_en   (load),
        .rd_addr (c_cur),
        .rd_data (older_rd)
    );

    // Forward the older-row write that lands on the same edge as its read
    assign byp_hit = s1_adv & !s1_virt_reg & (s1_col_reg == c_cur);
    assign s1_adv  = s1_valid_reg & s2_free;

    // Read stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s1_pix_reg     <= pix_new;
            s1_col_reg     <= c_cur;
            s1_virt_reg    <= virt;
            s1_last_reg    <= last_cur;
            s1_row1_reg    <= (row_reg != '0);
            s1_row2_reg    <= (row_reg >= ROW_W'(2));
            s1_c1_reg      <= (c_cur != '0);
            s1_c2_reg      <= (c_cur >= COL_W'(2));
            s1_byp_reg     <= byp_hit;
            s1_byp_pix_reg <= newer_rd;
        end
    end

    // New window column and the sums of both possible results
    always_comb
    begin
        col_t = s1_byp_reg ? s1_byp_pix_reg : older_rd;
        col_m = newer_rd;
        col_b = s1_pix_reg;

        cs_a = bblur_pkg::colsum(win_a_reg[0], win_a_reg[1], win_a_reg[2],
                                 s1_row2_reg, !s1_virt_reg);
        cs_b = bblur_pkg::colsum(win_b_reg[0], win_b_reg[1], win_b_reg[2],
                                 s1_row2_reg, !s1_virt_reg);
        cs_n = bblur_pkg::colsum(col_t, col_m, col_b, s1_row2_reg, !s1_virt_reg);

        nrows  = 2'd1 + {1'b0, s1_row2_reg} + {1'b0, !s1_virt_reg};
        ncols0 = 2'd2 + {1'b0, s1_c2_reg};
        ncols1 = 2'd1 + {1'b0, s1_c1_reg};

        // Result centered on the previous column
        res0.sum        = bblur_pkg::sum_add(bblur_pkg::sum_add(s1_c2_reg ? cs_a : '0, cs_b),
                                             cs_n);
        res0.count      = CNT_W'(nrows) * CNT_W'(ncols0);
        res0.frame_last = 1'b0;

        // Result centered on the row's last column
        res1.sum        = bblur_pkg::sum_add(s1_c1_reg ? cs_b : '0, cs_n);
        res1.count      = CNT_W'(nrows) * CNT_W'(ncols1);
        res1.frame_last = s1_virt_reg;

        r0v        = s1_row1_reg & s1_c1_reg;
        r1v        = s1_row1_reg & s1_last_reg;
        slot0_next = r0v ? res0 : res1;
        s1_any     = r0v | r1v;
        s1_two     = r0v & r1v;
    end

    // Shift the window, clear it at row end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win_a_reg[i] <= '0;
                win_b_reg[i] <= '0;
            end
        end
        else if (s1_adv)
        begin
            if (s1_last_reg)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    win_a_reg[i] <= '0;
                    win_b_reg[i] <= '0;
                end
            end
            else
            begin
                for (int i = 0; i < 3; i++)
                begin
                    win_a_reg[i] <= win_b_reg[i];
                end
                win_b_reg[0] <= col_t;
                win_b_reg[1] <= col_m;
                win_b_reg[2] <= col_b;
            end
        end
    end

    // Sum stage
    assign s2_adv  = s2_valid_reg & out_free;
    assign s2_free = !s2_valid_reg | out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            s2_valid_reg <= s1_any;
        end
        else if (s2_adv)
        begin
            s2_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s2_two_reg   <= s1_two;
            s2_slot0_reg <= slot0_next;
            s2_slot1_reg <= res1;
        end
    end

    // Output stage: one or two beats per item
    assign out_beat = out_valid_reg & m_axis_tready;
    assign out_done = out_beat & (!out_two_reg | out_sel_reg);
    assign out_free = !out_valid_reg | out_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_two_reg   <= 1'b0;
            out_sel_reg   <= 1'b0;
        end
        else if (s2_adv)
        begin
            out_valid_reg <= 1'b1;
            out_two_reg   <= s2_two_reg;
            out_sel_reg   <= 1'b0;
        end
        else if (out_done)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_beat)
        begin
            out_sel_reg <= 1'b1;
        end
    end

    // Divide into the result registers
    always_ff @(posedge clk)
    begin
        if (s2_adv)
        begin
            out0_reg <= bblur_pkg::div_slot(s2_slot0_reg);
            out1_reg <= bblur_pkg::div_slot(s2_slot1_reg);
        end
    end

    assign out_cur       = out_sel_reg ? out1_reg : out0_reg;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_cur.pix.blue, out_cur.pix.green, out_cur.pix.red};
    assign m_axis_tlast  = !out_two_reg | out_sel_reg;
    assign m_axis_tuser  = out_cur.frame_last;

endmodule

// ===== rtl/bblur_ram.sv =====
module bblur_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read; a read at the written address sees old data
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== bench/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CFG_W         = bblur_pkg::CFG_W;
    localparam int MAXW          = bblur_pkg::MAX_WIDTH_DEF;
    localparam int MAXH          = bblur_pkg::MAX_HEIGHT_DEF;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 20;
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int PRINT_LIMIT   = 100;
    localparam int FLUSH_PROBE   = 8;
    localparam int COLUMN_PROBE  = 40;

    // One expected output beat
    typedef struct packed
    {
        bblur_pkg::rgb_t pix;
        logic            run_last;
        logic            frame_last;
    } blurred_t;

    logic             clk;
    logic             rst_n;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [23:0]      s_axis_tdata;   // in_red, in_green, in_blue
    logic             s_axis_tuser;   // action
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [23:0]      m_axis_tdata;   // out_red, out_green, out_blue
    logic             m_axis_tlast;   // run_last
    logic             m_axis_tuser;   // frame_last
    logic             cfg_valid;
    logic             cfg_ready;
    logic             cfg_index;
    logic [CFG_W-1:0] cfg_data;

    // Blur predictor state
    logic [CFG_W-1:0] width_reg  = bblur_pkg::FRAME_WIDTH_RST;
    logic [CFG_W-1:0] height_reg = bblur_pkg::FRAME_HEIGHT_RST;
    bblur_pkg::rgb_t  older_line [MAXW];
    bblur_pkg::rgb_t  newer_line [MAXW];
    bblur_pkg::rgb_t  blur_win [9];
    int               col_pos = 0;
    int               row_pos = 0;
    blurred_t         blur_expect_q [$];

    // Run control and counters
    bit               idle_on = 1'b1;
    logic             long_hold;
    event             hold_start;
    int               items_taken  = 0;
    int               results_seen = 0;
    int               mismatches   = 0;
    int               cycle_count  = 0;

    box_blur_3x3_edge_aware dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Size actually used by the block: zero counts as one, large values saturate
    function automatic int effective_size(logic [CFG_W-1:0] v, int ceiling);
        if (v == '0)
            return 1;
        if (int'(v) > ceiling)
            return ceiling;
        return int'(v);
    endfunction

    // Push a new column into the right side of the window
    function automatic void shift_columns(bblur_pkg::rgb_t t, bblur_pkg::rgb_t m,
                                          bblur_pkg::rgb_t b);
        bblur_pkg::rgb_t col [3];
        col[0] = t;
        col[1] = m;
        col[2] = b;
        for (int r = 0; r < 3; r++)
        begin
            blur_win[r*3]     = blur_win[r*3 + 1];
            blur_win[r*3 + 1] = blur_win[r*3 + 2];
            blur_win[r*3 + 2] = col[r];
        end
    endfunction

    // Rounded mean of the in-frame part of the window, half up
    function automatic blurred_t window_mean(bit use_left, bit use_right, bit use_top,
                                             bit use_bottom, bit corner);
        blurred_t res;
        int       sr;
        int       sg;
        int       sb;
        int       cnt;
        sr  = 0;
        sg  = 0;
        sb  = 0;
        cnt = 0;
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                if (!((r == 0 && !use_top) || (r == 2 && !use_bottom) ||
                      (c == 0 && !use_left) || (c == 2 && !use_right)))
                begin
                    sr  += blur_win[r*3 + c].red;
                    sg  += blur_win[r*3 + c].green;
                    sb  += blur_win[r*3 + c].blue;
                    cnt++;
                end
        res.pix.red    = 8'((2*sr + cnt) / (2*cnt));
        res.pix.green  = 8'((2*sg + cnt) / (2*cnt));
        res.pix.blue   = 8'((2*sb + cnt) / (2*cnt));
        res.run_last   = 1'b0;
        res.frame_last = corner;
        return res;
    endfunction

    // Advance the predictor by one accepted beat; returns 0 if the beat is ignored
    function automatic bit predict_blur(bblur_pkg::action_t act, bblur_pkg::rgb_t px);
        int              w;
        int              h;
        int              r;
        int              c;
        int              n;
        bit              below;
        bit              row_end;
        bblur_pkg::rgb_t fresh;
        blurred_t        found [2];
        w     = effective_size(width_reg, MAXW);
        h     = effective_size(height_reg, MAXH);
        r     = row_pos;
        c     = (col_pos >= w) ? w - 1 : col_pos;
        below = (r >= h);
        n     = 0;
        // drop a flush that lands inside the frame
        if (act == bblur_pkg::ACT_FLUSH && !below)
            return 1'b0;
        if (below)
            fresh = '0;
        else
            fresh = px;
        shift_columns(older_line[c], newer_line[c], fresh);
        if (!below)
        begin
            older_line[c] = newer_line[c];
            newer_line[c] = fresh;
        end
        row_end = (c + 1 >= w);
        if (r >= 1)
        begin
            if (c >= 1)
            begin
                found[n] = window_mean(c >= 2, 1'b1, r >= 2, !below, 1'b0);
                n++;
            end
            // the row end also emits its own pixel with an empty right column
            if (row_end)
            begin
                shift_columns('0, '0, '0);
                found[n] = window_mean(c >= 1, 1'b0, r >= 2, !below, below);
                n++;
            end
            if (n > 0)
                found[n-1].run_last = 1'b1;
        end
        for (int k = 0; k < n; k++)
            blur_expect_q.push_back(found[k]);
        if (row_end)
        begin
            col_pos = 0;
            row_pos = below ? 0 : ((r + 1) & 'h7FF);
            foreach (blur_win[i])
                blur_win[i] = '0;
        end
        else
            col_pos = (c + 1) & 'h3FF;
        return 1'b1;
    endfunction

    function automatic bblur_pkg::rgb_t random_pixel();
        bblur_pkg::rgb_t p;
        p = bblur_pkg::rgb_t'(24'($urandom));
        // push some channels to the rails for rounding and overflow corners
        if ($urandom_range(0, 7) == 0)
        begin
            p.red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            p.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            p.blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end
        return p;
    endfunction

    function automatic logic [CFG_W-1:0] random_size();
        case ($urandom_range(0, 11))
            0:       return '0;
            1:       return CFG_W'(1);
            2:       return CFG_W'($urandom_range(13, 30));
            default: return CFG_W'($urandom_range(2, 12));
        endcase
    endfunction

    task automatic report_mismatch(string msg);
        if (mismatches < PRINT_LIMIT)
            $display("mismatch: %s", msg);
        mismatches++;
    endtask

    // Offer one beat, with an occasional gap first, and predict once it is taken
    task automatic send_item(bblur_pkg::action_t act, bblur_pkg::rgb_t px);
        if (idle_on && $urandom_range(0, 9) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {px.blue, px.green, px.red};
        s_axis_tuser  <= act;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (predict_blur(act, px))
            items_taken++;
    endtask

    // Hold until the block is quiet, then write one register
    task automatic write_reg(bblur_pkg::cfg_reg_t idx, logic [CFG_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        while (blur_expect_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == bblur_pkg::REG_FRAME_WIDTH)
            width_reg = value;
        else
            height_reg = value;
        col_pos = 0;
        row_pos = 0;
    endtask

    // One frame in raster order with stray flushes, then the flush row;
    // stop_after cuts the frame short after that many pixels
    task automatic send_frame(int w, int h, int stop_after);
        int sent;
        sent = 0;
        for (int r = 0; r < h; r++)
            for (int c = 0; c < w; c++)
            begin
                if (sent == stop_after)
                    return;
                if ($urandom_range(0, 19) == 0)
                    send_item(bblur_pkg::ACT_FLUSH, random_pixel());
                send_item(bblur_pkg::ACT_PIXEL, random_pixel());
                sent++;
            end
        for (int c = 0; c < w; c++)
            if ($urandom_range(0, 2) == 0)
                send_item(bblur_pkg::ACT_PIXEL, random_pixel());
            else
                send_item(bblur_pkg::ACT_FLUSH, random_pixel());
    endtask

    // 3x3 frame: corner, edge and centre divisors with rail values
    task automatic test_small_frame();
        logic [23:0] pats [9];
        pats = '{24'hFFFFFF, 24'h000000, 24'hFF00FF, 24'h00FF00, 24'hAA55AA,
                 24'h55AA55, 24'hFFFFFF, 24'h010203, 24'hFEFDFC};
        write_reg(bblur_pkg::REG_FRAME_WIDTH, CFG_W'(3));
        write_reg(bblur_pkg::REG_FRAME_HEIGHT, CFG_W'(3));
        for (int i = 0; i < 9; i++)
        begin
            send_item(bblur_pkg::ACT_PIXEL, bblur_pkg::rgb_t'(pats[i]));
            // a flush inside the frame must be ignored
            if (i == 3)
                send_item(bblur_pkg::ACT_FLUSH, bblur_pkg::rgb_t'(24'hFFFFFF));
        end
        // flush row; the pixel in it counts as a flush
        send_item(bblur_pkg::ACT_FLUSH, bblur_pkg::rgb_t'(24'h000000));
        send_item(bblur_pkg::ACT_PIXEL, bblur_pkg::rgb_t'(24'hFFFFFF));
        send_item(bblur_pkg::ACT_FLUSH, bblur_pkg::rgb_t'(24'h123456));
    endtask

    // Restart mid-frame on a register write, then zero sizes used as one
    task automatic test_restart_and_clamp();
        write_reg(bblur_pkg::REG_FRAME_WIDTH, CFG_W'(2));
        write_reg(bblur_pkg::REG_FRAME_HEIGHT, CFG_W'(2));
        send_item(bblur_pkg::ACT_PIXEL, bblur_pkg::rgb_t'(24'h102030));
        send_item(bblur_pkg::ACT_PIXEL, bblur_pkg::rgb_t'(24'hF0E0D0));
        send_item(bblur_pkg::ACT_PIXEL, bblur_pkg::rgb_t'(24'h7F807F));
        write_reg(bblur_pkg::REG_FRAME_HEIGHT, '0);
        send_item(bblur_pkg::ACT_PIXEL, bblur_pkg::rgb_t'(24'hFF0001));
        send_item(bblur_pkg::ACT_PIXEL, bblur_pkg::rgb_t'(24'h00FF01));
        send_item(bblur_pkg::ACT_FLUSH, bblur_pkg::rgb_t'(24'h000000));
        send_item(bblur_pkg::ACT_FLUSH, bblur_pkg::rgb_t'(24'hFFFFFF));
        write_reg(bblur_pkg::REG_FRAME_WIDTH, '0);
        send_item(bblur_pkg::ACT_PIXEL, bblur_pkg::rgb_t'(24'hFFFFFF));
        send_item(bblur_pkg::ACT_FLUSH, bblur_pkg::rgb_t'(24'h000000));
        // back-to-back 1x1 frame, closed by a pixel below the frame
        send_item(bblur_pkg::ACT_PIXEL, bblur_pkg::rgb_t'(24'h818283));
        send_item(bblur_pkg::ACT_PIXEL, bblur_pkg::rgb_t'(24'hFFFFFF));
    endtask

    // Random sizes, a few frames per setting, some frames cut short
    task automatic test_random_frames(int budget);
        int               stop_at;
        int               w;
        int               h;
        int               frames;
        logic [CFG_W-1:0] w_val;
        logic [CFG_W-1:0] h_val;
        stop_at = items_taken + budget;
        while (items_taken < stop_at)
        begin
            w_val = random_size();
            h_val = random_size();
            if ($urandom_range(0, 1))
            begin
                write_reg(bblur_pkg::REG_FRAME_WIDTH, w_val);
                write_reg(bblur_pkg::REG_FRAME_HEIGHT, h_val);
            end
            else
            begin
                write_reg(bblur_pkg::REG_FRAME_HEIGHT, h_val);
                write_reg(bblur_pkg::REG_FRAME_WIDTH, w_val);
            end
            w = effective_size(w_val, MAXW);
            h = effective_size(h_val, MAXH);
            frames = $urandom_range(1, 3);
            for (int f = 0; f < frames && items_taken < stop_at; f++)
                send_frame(w, h, ($urandom_range(0, 7) == 0) ?
                                 $urandom_range(0, w*h - 1) : -1);
        end
    endtask

    // Sizes above the maximum saturate: a full-width row pushed out by a few
    // flushes, then the first rows of a full-height column
    task automatic test_max_sizes();
        write_reg(bblur_pkg::REG_FRAME_WIDTH, '1);
        write_reg(bblur_pkg::REG_FRAME_HEIGHT, CFG_W'(1));
        for (int c = 0; c < MAXW; c++)
            send_item(bblur_pkg::ACT_PIXEL, random_pixel());
        for (int c = 0; c < FLUSH_PROBE; c++)
            send_item(bblur_pkg::ACT_FLUSH, random_pixel());
        write_reg(bblur_pkg::REG_FRAME_WIDTH, CFG_W'(1));
        write_reg(bblur_pkg::REG_FRAME_HEIGHT, '1);
        send_frame(1, MAXH, COLUMN_PROBE);
    endtask

    // Stall the output for a long stretch while a frame keeps coming
    task automatic test_backpressure();
        write_reg(bblur_pkg::REG_FRAME_WIDTH, CFG_W'(10));
        write_reg(bblur_pkg::REG_FRAME_HEIGHT, CFG_W'(5));
        -> hold_start;
        send_frame(10, 5, -1);
    endtask

    task automatic finish_run();
        s_axis_tvalid <= 1'b0;
        while (blur_expect_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= bblur_pkg::ACT_PIXEL;
        cfg_valid     <= 1'b0;
        cfg_index     <= bblur_pkg::REG_FRAME_WIDTH;
        cfg_data      <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_small_frame();
        test_restart_and_clamp();
        test_random_frames(250);
        test_max_sizes();
        test_backpressure();
        // closing stretch without gaps or stalls
        idle_on = 1'b0;
        test_random_frames(150);
        finish_run();
    end

    // Long output hold, counted here while the sender keeps going
    initial
    begin
        long_hold <= 1'b0;
        forever
        begin
            @(hold_start);
            long_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            long_hold <= 1'b0;
        end
    end

    // Output ready: random stall bursts, or held low during a long hold
    initial
    begin
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold)
                m_axis_tready <= 1'b0;
            else if (idle_on && $urandom_range(0, 11) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Compare each output beat with the oldest expected one
    always @(posedge clk)
    begin : check_results
        blurred_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (blur_expect_q.size() == 0)
                report_mismatch($sformatf("result %0d arrived with none expected",
                                          results_seen));
            else
            begin
                want = blur_expect_q.pop_front();
                if (m_axis_tdata[7:0] !== want.pix.red)
                    report_mismatch($sformatf("result %0d red %0d, expected %0d",
                                    results_seen, m_axis_tdata[7:0], want.pix.red));
                if (m_axis_tdata[15:8] !== want.pix.green)
                    report_mismatch($sformatf("result %0d green %0d, expected %0d",
                                    results_seen, m_axis_tdata[15:8], want.pix.green));
                if (m_axis_tdata[23:16] !== want.pix.blue)
                    report_mismatch($sformatf("result %0d blue %0d, expected %0d",
                                    results_seen, m_axis_tdata[23:16], want.pix.blue));
                if (m_axis_tlast !== want.run_last)
                    report_mismatch($sformatf("result %0d run_last %0b, expected %0b",
                                    results_seen, m_axis_tlast, want.run_last));
                if (m_axis_tuser !== want.frame_last)
                    report_mismatch($sformatf("result %0d frame_last %0b, expected %0b",
                                    results_seen, m_axis_tuser, want.frame_last));
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

endmodule

// ===== files.f =====
rtl/bblur_pkg.sv
rtl/bblur_ram.sv
rtl/box_blur_3x3_edge_aware.sv
bench/testbench.sv
